// ----- sv/alu8f_pkg.sv -----
// Shared definitions for the 8-bit ALU with flags: operation codes, flag bit positions, widths and the result type.
// This file depends on nothing. The ALU core and the top level import it.
`default_nettype none

package alu8f_pkg;

  // Operation codes. Codes six and seven are unused and pass the accumulator through.
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_DAA = 3'd2,
    OP_AND = 3'd3,
    OP_XOR = 3'd4,
    OP_OR  = 3'd5
  } alu8f_op_e;

  // Bit positions in the flag word and in the update mask.
  localparam int unsigned FlagCy = 0;
  localparam int unsigned FlagZ  = 1;
  localparam int unsigned FlagS  = 2;
  localparam int unsigned FlagP  = 3;
  localparam int unsigned FlagAc = 4;

  localparam int unsigned FlagW  = 5;
  localparam int unsigned DataW  = 8;
  localparam int unsigned OpW    = 3;
  localparam int unsigned TagW   = 4;

  // This is the result of one pass through the core.
  typedef struct packed {
    logic [DataW-1:0] result;
    logic [FlagW-1:0] flags;
  } alu8f_res_t;

endpackage

`default_nettype wire

// ----- sv/alu_8bit_with_flags_top.sv -----
// Top level of the 8-bit ALU with flags: the input stage, the flag register and the result register.
// This file depends on alu8f_pkg and alu8f_core.
//
// Usage:
//   A request carries an opcode, two operand bytes, a carry-in enable, a
//   flag update mask and a destination tag. The request is taken at a clock edge
//   where in_valid_i is high and in_stall_o is low. The result byte, the tag
//   and the updated flag word appear on the output channel. They are taken where
//   out_valid_o is high and out_stall_i is low.
//   A taken request goes into the input register and, from there, into the
//   output register. The block sustains one request per clock while out_stall_i
//   is low. The input register feeds the ALU core, and the core result goes
//   into the output register. The flag register updates as a request moves
//   into the output register, so the next request already sees the new flags.
//   Reset clears both valid bits and all five flags.
//   When the receiver stalls, the output register holds its contents. The
//   input register still moves forward while the output register is empty.
//   Once both stages are full, in_stall_o rises.
`default_nettype none

module alu_8bit_with_flags_top
  import alu8f_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [OpW-1:0]   op_i,
  input  wire logic [DataW-1:0] act_value_i,
  input  wire logic [DataW-1:0] tmp_value_i,
  input  wire logic             carry_in_enable_i,
  input  wire logic [FlagW-1:0] flag_mask_i,
  input  wire logic [TagW-1:0]  dest_tag_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [DataW-1:0]      result_o,
  output logic [TagW-1:0]       dest_tag_out_o,
  output logic [FlagW-1:0]      flags_o
);

  logic             s1_valid_q;
  logic [OpW-1:0]   s1_op_q;
  logic [DataW-1:0] s1_act_q;
  logic [DataW-1:0] s1_tmp_q;
  logic             s1_cin_q;
  logic [FlagW-1:0] s1_mask_q;
  logic [TagW-1:0]  s1_tag_q;

  logic             out_valid_q;
  logic [DataW-1:0] out_res_q;
  logic [TagW-1:0]  out_tag_q;
  logic [FlagW-1:0] out_flags_q;

  logic [FlagW-1:0] flags_q;
  logic [FlagW-1:0] flags_d;

  logic       out_load;
  logic       s1_move;
  logic       s1_load;
  alu8f_res_t core_res;

  // Handshake control. The output register loads when it is empty or being drained.
  assign out_load   = ~out_valid_q | ~out_stall_i;
  assign s1_move    = s1_valid_q & out_load;
  assign in_stall_o = s1_valid_q & ~out_load;
  assign s1_load    = in_valid_i & ~in_stall_o;

  alu8f_core u_core (
    .op_i     (s1_op_q),
    .act_i    (s1_act_q),
    .tmp_i    (s1_tmp_q),
    .cin_en_i (s1_cin_q),
    .mask_i   (s1_mask_q),
    .flags_i  (flags_q),
    .res_o    (core_res)
  );

  assign flags_d = s1_move ? core_res.flags : flags_q;

  // Valid bits of both stages and flag state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      flags_q <= flags_d;
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_op_q   <= op_i;
      s1_act_q  <= act_value_i;
      s1_tmp_q  <= tmp_value_i;
      s1_cin_q  <= carry_in_enable_i;
      s1_mask_q <= flag_mask_i;
      s1_tag_q  <= dest_tag_i;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_res_q   <= core_res.result;
      out_tag_q   <= s1_tag_q;
      out_flags_q <= core_res.flags;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_o       = out_res_q;
  assign dest_tag_out_o = out_tag_q;
  assign flags_o        = out_flags_q;

endmodule

`default_nettype wire

// ----- sv/alu8f_core.sv -----
// Combinational ALU datapath: it computes the result byte and the updated flag word.
// This file depends on alu8f_pkg.
`default_nettype none

module alu8f_core
  import alu8f_pkg::*;
(
  input  wire logic [OpW-1:0]   op_i,
  input  wire logic [DataW-1:0] act_i,
  input  wire logic [DataW-1:0] tmp_i,
  input  wire logic             cin_en_i,
  input  wire logic [FlagW-1:0] mask_i,
  input  wire logic [FlagW-1:0] flags_i,
  output alu8f_res_t            res_o
);

  logic       cy_old;
  logic       ac_old;
  logic       cin;
  logic [9:0] sub_wide;
  logic [5:0] sub_nib;
  logic [8:0] add_wide;
  logic [4:0] add_nib;
  logic       daa_lo;
  logic       daa_hi;
  logic [8:0] daa_w1;
  logic [8:0] daa_w2;
  logic [4:0] daa_nib;
  logic [7:0] res_byte;
  logic       cy_new;
  logic       ac_new;
  logic       known_op;
  logic [FlagW-1:0] calc_flags;

  assign cy_old = flags_i[FlagCy];
  assign ac_old = flags_i[FlagAc];
  assign cin    = cin_en_i & cy_old;

  // The adder and the subtractor take both the full byte and the low nibble.
  assign add_wide = {1'b0, act_i} + {1'b0, tmp_i} + {8'd0, cin};
  assign add_nib  = {1'b0, act_i[3:0]} + {1'b0, tmp_i[3:0]} + {4'd0, cin};
  assign sub_wide = {2'b00, act_i} - ({2'b00, tmp_i} + {9'd0, cin});
  assign sub_nib  = {2'b00, act_i[3:0]} - ({2'b00, tmp_i[3:0]} + {5'd0, cin});

  // Decimal adjust first corrects the low digit. The high digit is then checked
  // on the corrected value.
  assign daa_lo  = (act_i[3:0] > 4'd9) | ac_old;
  assign daa_w1  = {1'b0, act_i} + (daa_lo ? 9'h006 : 9'h000);
  assign daa_nib = {1'b0, act_i[3:0]} + (daa_lo ? 5'h06 : 5'h00);
  assign daa_hi  = (daa_w1[7:4] > 4'd9) | cy_old;
  assign daa_w2  = daa_w1 + (daa_hi ? 9'h060 : 9'h000);

  // Select the result byte and the new carry and auxiliary carry for each operation.
  always_comb begin
    res_byte = act_i;
    cy_new   = 1'b0;
    ac_new   = 1'b0;
    known_op = 1'b1;
    case (op_i)
      OP_ADD: begin
        res_byte = add_wide[7:0];
        cy_new   = add_wide[8];
        ac_new   = add_nib[4];
      end
      OP_SUB: begin
        res_byte = sub_wide[7:0];
        cy_new   = sub_wide[8];
        ac_new   = sub_nib[4];
      end
      OP_DAA: begin
        res_byte = daa_w2[7:0];
        cy_new   = daa_w2[8] | cy_old;
        ac_new   = daa_nib[4];
      end
      OP_AND: begin
        res_byte = act_i & tmp_i;
        ac_new   = act_i[3] | tmp_i[3];
      end
      OP_XOR: begin
        res_byte = act_i ^ tmp_i;
      end
      OP_OR: begin
        res_byte = act_i | tmp_i;
      end
      default: begin
        known_op = 1'b0;
      end
    endcase
  end

  // Each flag is updated only where its mask bit is set. An unused opcode changes no flag.
  always_comb begin
    calc_flags         = flags_i;
    calc_flags[FlagCy] = mask_i[FlagCy] ? cy_new : flags_i[FlagCy];
    calc_flags[FlagZ]  = mask_i[FlagZ] ? (res_byte == 8'd0) : flags_i[FlagZ];
    calc_flags[FlagS]  = mask_i[FlagS] ? res_byte[7] : flags_i[FlagS];
    calc_flags[FlagP]  = mask_i[FlagP] ? ~(^res_byte) : flags_i[FlagP];
    calc_flags[FlagAc] = mask_i[FlagAc] ? ac_new : flags_i[FlagAc];
  end

  assign res_o.result = res_byte;
  assign res_o.flags  = known_op ? calc_flags : flags_i;

endmodule

`default_nettype wire
